### hw/rtl/wsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, widths and register codes of the world-to-screen projection.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int FRAC_BITS = 16;

    localparam int PT_W     = 32;                        // point and weight width
    localparam int PROD_W   = 2 * PT_W;                  // one weight product
    localparam int SUM_W    = PROD_W + 2;                // sum of three products
    localparam int CLIP_W   = SUM_W - FRAC_BITS + 2;     // clip value, signed
    localparam int NUM_W    = CLIP_W + FRAC_BITS;        // dividend |clip| << F
    localparam int QUO_W    = 41;                        // ndc quotient bits
    localparam int NDC_W    = QUO_W + 1;                 // signed ndc
    localparam int VIEW_W   = 14;
    localparam int HALF_W   = VIEW_W - 1;
    localparam int SCL_W    = NDC_W + 1;                 // 1 +/- ndc
    localparam int VP_W     = SCL_W + VIEW_W;            // half size * (1 +/- ndc)
    localparam int REG_W    = 64;
    localparam int ADDR_W   = 6;
    localparam int IDX_W    = 3;

    localparam logic signed [CLIP_W-1:0] W_MIN =
        CLIP_W'(((64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);
    localparam logic [QUO_W-1:0] NDC_CAP = QUO_W'(64'd1 << (QUO_W - 1));
    localparam logic signed [SCL_W-1:0] ONE = SCL_W'(64'd1 << FRAC_BITS);

    localparam logic [IDX_W-1:0] REG_XCOL_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_XCOL_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_YCOL_A = 3'd2;
    localparam logic [IDX_W-1:0] REG_YCOL_B = 3'd3;
    localparam logic [IDX_W-1:0] REG_WCOL_A = 3'd4;
    localparam logic [IDX_W-1:0] REG_WCOL_B = 3'd5;
    localparam logic [IDX_W-1:0] REG_VIEW_W = 3'd6;
    localparam logic [IDX_W-1:0] REG_VIEW_H = 3'd7;

    typedef struct packed {
        logic [REG_W-1:0]  xcol_a;
        logic [REG_W-1:0]  xcol_b;
        logic [REG_W-1:0]  ycol_a;
        logic [REG_W-1:0]  ycol_b;
        logic [REG_W-1:0]  wcol_a;
        logic [REG_W-1:0]  wcol_b;
        logic [VIEW_W-1:0] view_w;
        logic [VIEW_W-1:0] view_h;
    } t_cfg;

endpackage

### hw/rtl/world_to_screen_projection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects a Q16.16 world point to window coordinates through a 3x4 matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_point_x/y/z and pulse start. busy is tied low,
//   so a point is taken at every rising edge with start high, one per cycle.
//   Result channel: o_valid is high for one cycle with o_on_screen,
//   o_screen_x and o_screen_y; the receiver must take it in that cycle.
//   Pipeline: an accepted point passes 3 clip stages, then 43 divider
//   stages, then 2 viewport stages that raise the strobe. Throughput is one
//   point per cycle, set by the bit-per-stage ndc dividers.
//   Configuration: APB, 64-bit data, register i at byte address 8*i; write
//   only while no point is in flight. pready is always high.
//   Points with clip w below 0.001 come out with on_screen and both
//   coordinates zero. Coordinates saturate to the signed 32-bit range.
//   Reset (synchronous, active low) drops every point in flight and loads
//   the default matrix and a 1920x1080 window.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit import wsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [PT_W-1:0] i_point_x,
    input  logic signed [PT_W-1:0] i_point_y,
    input  logic signed [PT_W-1:0] i_point_z,
    output logic                   o_valid,
    output logic                   o_on_screen,
    output logic signed [PT_W-1:0] o_screen_x,
    output logic signed [PT_W-1:0] o_screen_y,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [REG_W-1:0]       pwdata,
    output logic [REG_W-1:0]       prdata,
    output logic                   pready
);

    t_cfg              cfg;
    logic              clip_vld, clip_on, neg_x, neg_y;
    logic [CLIP_W-1:0] mag_x, mag_y, den;
    logic              dx_vld, dy_vld, dx_tag, dy_tag;
    logic signed [NDC_W-1:0] ndc_x, ndc_y;

    assign busy = 1'b0;

    wsp_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wsp_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_cfg   (cfg),
        .o_vld   (clip_vld),
        .o_on    (clip_on),
        .o_mag_x (mag_x),
        .o_mag_y (mag_y),
        .o_neg_x (neg_x),
        .o_neg_y (neg_y),
        .o_den   (den)
    );

    wsp_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (clip_vld),
        .i_tag   (clip_on),
        .i_mag   (mag_x),
        .i_neg   (neg_x),
        .i_den   (den),
        .o_vld   (dx_vld),
        .o_tag   (dx_tag),
        .o_ndc   (ndc_x)
    );

    wsp_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (clip_vld),
        .i_tag   (clip_on),
        .i_mag   (mag_y),
        .i_neg   (neg_y),
        .i_den   (den),
        .o_vld   (dy_vld),
        .o_tag   (dy_tag),
        .o_ndc   (ndc_y)
    );

    wsp_viewport u_vp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dx_vld & dy_vld),
        .i_on    (dx_tag & dy_tag),
        .i_ndc_x (ndc_x),
        .i_ndc_y (ndc_y),
        .i_cfg   (cfg),
        .o_vld   (o_valid),
        .o_on    (o_on_screen),
        .o_sx    (o_screen_x),
        .o_sy    (o_screen_y)
    );

endmodule

### hw/rtl/wsp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_cfg_regs
// APB register file holding the projection columns and the window size.
// ----------------------------------------------------------------------------
module wsp_cfg_regs import wsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    logic [IDX_W-1:0] idx;
    logic             wr;

    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xcol_a <= 64'h1_0000_0000;
            r_cfg.xcol_b <= '0;
            r_cfg.ycol_a <= 64'd65536;
            r_cfg.ycol_b <= '0;
            r_cfg.wcol_a <= '0;
            r_cfg.wcol_b <= 64'd65536;
            r_cfg.view_w <= VIEW_W'(1920);
            r_cfg.view_h <= VIEW_W'(1080);
        end else if (wr) begin
            unique case (idx)
                REG_XCOL_A: r_cfg.xcol_a <= pwdata;
                REG_XCOL_B: r_cfg.xcol_b <= pwdata;
                REG_YCOL_A: r_cfg.ycol_a <= pwdata;
                REG_YCOL_B: r_cfg.ycol_b <= pwdata;
                REG_WCOL_A: r_cfg.wcol_a <= pwdata;
                REG_WCOL_B: r_cfg.wcol_b <= pwdata;
                REG_VIEW_W: r_cfg.view_w <= pwdata[VIEW_W-1:0];
                REG_VIEW_H: r_cfg.view_h <= pwdata[VIEW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_XCOL_A: prdata = r_cfg.xcol_a;
            REG_XCOL_B: prdata = r_cfg.xcol_b;
            REG_YCOL_A: prdata = r_cfg.ycol_a;
            REG_YCOL_B: prdata = r_cfg.ycol_b;
            REG_WCOL_A: prdata = r_cfg.wcol_a;
            REG_WCOL_B: prdata = r_cfg.wcol_b;
            REG_VIEW_W: prdata = REG_W'(r_cfg.view_w);
            REG_VIEW_H: prdata = REG_W'(r_cfg.view_h);
            default:    prdata = '0;
        endcase
    end

endmodule

### hw/rtl/wsp_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_clip
// Three stages: nine weight products, column sums, threshold and magnitudes.
// ----------------------------------------------------------------------------
module wsp_clip import wsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [PT_W-1:0]   i_x,
    input  logic signed [PT_W-1:0]   i_y,
    input  logic signed [PT_W-1:0]   i_z,
    input  t_cfg                     i_cfg,
    output logic                     o_vld,
    output logic                     o_on,
    output logic [CLIP_W-1:0]        o_mag_x,
    output logic [CLIP_W-1:0]        o_mag_y,
    output logic                     o_neg_x,
    output logic                     o_neg_y,
    output logic [CLIP_W-1:0]        o_den
);

    // stage 1: products, three per column
    logic                     r_vld1;
    logic signed [PROD_W-1:0] r_p [9];
    // stage 2: clip values
    logic                     r_vld2;
    logic signed [CLIP_W-1:0] r_cx, r_cy, r_cw;
    // stage 3
    logic                     r_vld3, r_on;
    logic [CLIP_W-1:0]        r_mag_x, r_mag_y, r_den;
    logic                     r_neg_x, r_neg_y;

    // floor of the exact sum of the three products, then the column offset
    function automatic logic signed [CLIP_W-1:0] col_sum(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b,
        input logic signed [PROD_W-1:0] c,
        input logic [PT_W-1:0]          off
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] sh;
        s  = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        sh = s >>> FRAC_BITS;
        return sh[CLIP_W-1:0] + CLIP_W'($signed(off));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= i_x * $signed(i_cfg.xcol_a[63:32]);
        r_p[1] <= i_y * $signed(i_cfg.xcol_a[31:0]);
        r_p[2] <= i_z * $signed(i_cfg.xcol_b[63:32]);
        r_p[3] <= i_x * $signed(i_cfg.ycol_a[63:32]);
        r_p[4] <= i_y * $signed(i_cfg.ycol_a[31:0]);
        r_p[5] <= i_z * $signed(i_cfg.ycol_b[63:32]);
        r_p[6] <= i_x * $signed(i_cfg.wcol_a[63:32]);
        r_p[7] <= i_y * $signed(i_cfg.wcol_a[31:0]);
        r_p[8] <= i_z * $signed(i_cfg.wcol_b[63:32]);

        r_cx <= col_sum(r_p[0], r_p[1], r_p[2], i_cfg.xcol_b[31:0]);
        r_cy <= col_sum(r_p[3], r_p[4], r_p[5], i_cfg.ycol_b[31:0]);
        r_cw <= col_sum(r_p[6], r_p[7], r_p[8], i_cfg.wcol_b[31:0]);

        r_on    <= (r_cw >= W_MIN);
        r_neg_x <= r_cx[CLIP_W-1];
        r_neg_y <= r_cy[CLIP_W-1];
        r_mag_x <= r_cx[CLIP_W-1] ? CLIP_W'(-r_cx) : CLIP_W'(r_cx);
        r_mag_y <= r_cy[CLIP_W-1] ? CLIP_W'(-r_cy) : CLIP_W'(r_cy);
        r_den   <= CLIP_W'(r_cw);
    end

    assign o_vld   = r_vld3;
    assign o_on    = r_on;
    assign o_mag_x = r_mag_x;
    assign o_mag_y = r_mag_y;
    assign o_neg_x = r_neg_x;
    assign o_neg_y = r_neg_y;
    assign o_den   = r_den;

endmodule

### hw/rtl/wsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider, one quotient bit per stage, for one ndc lane.
// Quotient is (|num| << F) / den, capped at 2^40, then signed.
// ----------------------------------------------------------------------------
module wsp_div import wsp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_tag,
    input  logic [CLIP_W-1:0]       i_mag,
    input  logic                    i_neg,
    input  logic [CLIP_W-1:0]       i_den,
    output logic                    o_vld,
    output logic                    o_tag,
    output logic signed [NDC_W-1:0] o_ndc
);

    logic              r_vld [QUO_W+1];
    logic              r_tag [QUO_W+1];
    logic              r_neg [QUO_W+1];
    logic              r_ovf [QUO_W+1];
    logic [CLIP_W-1:0] r_rem [QUO_W+1];
    logic [CLIP_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0]  r_low [QUO_W+1];
    logic [QUO_W-1:0]  r_q   [QUO_W+1];

    logic [NUM_W-1:0]  num;
    logic [QUO_W-1:0]  res;
    logic              r_ovld, r_otag;
    logic signed [NDC_W-1:0] r_ndc;

    assign num = {i_mag, {FRAC_BITS{1'b0}}};

    // entry stage: quotient would need more than QUO_W bits -> capped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_neg[0] <= i_neg;
        r_den[0] <= i_den;
        r_ovf[0] <= ((CLIP_W + 1)'(num[NUM_W-1:QUO_W]) >= (CLIP_W + 1)'(i_den));
        r_rem[0] <= CLIP_W'(num[NUM_W-1:QUO_W]);
        r_low[0] <= num[QUO_W-1:0];
        r_q[0]   <= '0;
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [CLIP_W:0] trial;
        logic [CLIP_W:0] diff;
        logic            ge;

        assign trial = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign diff  = trial - {1'b0, r_den[k-1]};
        assign ge    = (trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_tag[k] <= r_tag[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_den[k] <= r_den[k-1];
            r_rem[k] <= ge ? diff[CLIP_W-1:0] : trial[CLIP_W-1:0];
            r_low[k] <= {r_low[k-1][QUO_W-2:0], 1'b0};
            r_q[k]   <= {r_q[k-1][QUO_W-2:0], ge};
        end
    end

    assign res = (r_ovf[QUO_W] | r_q[QUO_W][QUO_W-1]) ? NDC_CAP
                                                      : {1'b0, r_q[QUO_W][QUO_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_otag <= r_tag[QUO_W];
        r_ndc  <= r_neg[QUO_W] ? -$signed({1'b0, res}) : $signed({1'b0, res});
    end

    assign o_vld = r_ovld;
    assign o_tag = r_otag;
    assign o_ndc = r_ndc;

endmodule

### hw/rtl/wsp_viewport.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_viewport
// Window mapping: half size times (1 +/- ndc), then saturation to 32 bits.
// ----------------------------------------------------------------------------
module wsp_viewport import wsp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_on,
    input  logic signed [NDC_W-1:0] i_ndc_x,
    input  logic signed [NDC_W-1:0] i_ndc_y,
    input  t_cfg                    i_cfg,
    output logic                    o_vld,
    output logic                    o_on,
    output logic signed [PT_W-1:0]  o_sx,
    output logic signed [PT_W-1:0]  o_sy
);

    localparam logic signed [VP_W-1:0] SAT_HI = VP_W'(64'sd2147483647);
    localparam logic signed [VP_W-1:0] SAT_LO = -VP_W'(64'sd2147483648);

    logic signed [VIEW_W-1:0] half_w, half_h;
    logic signed [SCL_W-1:0]  scl_x, scl_y;

    logic                     r_vld_a, r_on_a;
    logic signed [VP_W-1:0]   r_px, r_py;
    logic                     r_vld_b, r_on_b;
    logic signed [PT_W-1:0]   r_sx, r_sy;

    function automatic logic signed [PT_W-1:0] sat(input logic signed [VP_W-1:0] v);
        if (v > SAT_HI) begin
            return PT_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return PT_W'(SAT_LO);
        end
        return v[PT_W-1:0];
    endfunction

    assign half_w = $signed({1'b0, i_cfg.view_w[VIEW_W-1:1]});
    assign half_h = $signed({1'b0, i_cfg.view_h[VIEW_W-1:1]});
    assign scl_x  = ONE + SCL_W'(i_ndc_x);
    assign scl_y  = ONE - SCL_W'(i_ndc_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_on_a <= i_on;
        r_px   <= VP_W'(half_w) * VP_W'(scl_x);
        r_py   <= VP_W'(half_h) * VP_W'(scl_y);
        r_on_b <= r_on_a;
        r_sx   <= r_on_a ? sat(r_px) : '0;
        r_sy   <= r_on_a ? sat(r_py) : '0;
    end

    assign o_vld = r_vld_b;
    assign o_on  = r_on_b;
    assign o_sx  = r_sx;
    assign o_sy  = r_sy;

endmodule
